/* rtl/core/lru_write_back_record_cache_unit_assert.svh */
// Assertion macros for the record cache checker
`ifndef LRU_WRITE_BACK_RECORD_CACHE_UNIT_ASSERT_SVH
`define LRU_WRITE_BACK_RECORD_CACHE_UNIT_ASSERT_SVH

// same-cycle implication
`define LWBRC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("record cache assertion failed");

// next-cycle implication
`define LWBRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("record cache assertion failed");

`endif

/* rtl/core/lwbrc_pkg.sv */
// Package: codes and controller/datapath interface types for the record cache
`timescale 1ns / 1ps
package lwbrc_pkg;

  localparam logic [1:0] CMD_GET   = 2'd0;
  localparam logic [1:0] CMD_FILL  = 2'd1;
  localparam logic [1:0] CMD_PUT   = 2'd2;
  localparam logic [1:0] CMD_FLUSH = 2'd3;

  localparam logic [1:0] KIND_HIT       = 2'd0;
  localparam logic [1:0] KIND_MISS      = 2'd1;
  localparam logic [1:0] KIND_WRITEBACK = 2'd2;
  localparam logic [1:0] KIND_DONE      = 2'd3;

  localparam logic [1:0] RD_HIT    = 2'd0;
  localparam logic [1:0] RD_VICTIM = 2'd1;
  localparam logic [1:0] RD_FLUSH  = 2'd2;

  typedef struct packed {
    logic       load_in;
    logic       rd_en;
    logic [1:0] rd_src;
    logic       promote;
    logic       put_hit;
    logic       install;
    logic       clear_dirty;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       out_load;
    logic [1:0] out_kind;
    logic       out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       hit;
    logic       victim_dirty;
    logic       flush_dirty;
    logic       cnt_last;
    logic       out_free;
  } dp_status_t;

endpackage

/* rtl/core/lwbrc_ram.sv */
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module lwbrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/lwbrc_dpath.sv */
// Datapath: tag compare, valid/dirty/rank state, record RAM and result register
`timescale 1ns / 1ps
module lwbrc_dpath #(
  parameter int WAYS        = 8,
  parameter int RECORD_BITS = 32,
  parameter int INDEX_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lwbrc_pkg::ctrl_cmd_t   cmd,
  output lwbrc_pkg::dp_status_t  status,
  input  logic [1:0]             command,
  input  logic [INDEX_BITS-1:0]  record_index,
  input  logic [RECORD_BITS-1:0] record_data,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [1:0]             kind,
  output logic [INDEX_BITS-1:0]  out_index,
  output logic [RECORD_BITS-1:0] out_data,
  output logic                   last
);
  import lwbrc_pkg::*;

  localparam int AW = $clog2(WAYS);
  localparam int RW = AW;
  localparam int EW = INDEX_BITS + RECORD_BITS;

  logic [1:0]             cmd_q;
  logic [INDEX_BITS-1:0]  idx_q;
  logic [RECORD_BITS-1:0] data_q;

  logic                  valid [WAYS];
  logic                  dirty [WAYS];
  logic [INDEX_BITS-1:0] tag   [WAYS];
  logic [RW-1:0]         rank  [WAYS];
  logic [RW-1:0]         cnt;

  logic [WAYS-1:0] hit_vec;
  logic [AW-1:0]   hit_way;
  logic [AW-1:0]   victim_way;
  logic [AW-1:0]   flush_way;
  logic [AW-1:0]   promo_way;
  logic [AW-1:0]   raddr;
  logic [AW-1:0]   waddr;
  logic            we;
  logic [EW-1:0]   rdata;

  always_comb begin
    hit_way    = '0;
    victim_way = '0;
    flush_way  = '0;
    for (int i = 0; i < WAYS; i++) begin
      hit_vec[i] = valid[i] && (tag[i] == idx_q);
      if (hit_vec[i]) begin
        hit_way = hit_way | AW'(i);
      end
      if (rank[i] == RW'(WAYS - 1)) begin
        victim_way = victim_way | AW'(i);
      end
      if (rank[i] == cnt) begin
        flush_way = flush_way | AW'(i);
      end
    end
  end

  assign promo_way = cmd.install ? victim_way : hit_way;

  always_comb begin
    case (cmd.rd_src)
      RD_HIT:    raddr = hit_way;
      RD_VICTIM: raddr = victim_way;
      RD_FLUSH:  raddr = flush_way;
      default:   raddr = hit_way;
    endcase
  end

  assign we    = cmd.install || cmd.put_hit;
  assign waddr = cmd.install ? victim_way : hit_way;

  lwbrc_ram #(
    .WIDTH(EW),
    .DEPTH(WAYS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata({idx_q, data_q}),
    .re   (cmd.rd_en),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_q  <= command;
      idx_q  <= record_index;
      data_q <= record_data;
    end
    if (cmd.install) begin
      tag[victim_way] <= idx_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WAYS; i++) begin
        valid[i] <= 1'b0;
        dirty[i] <= 1'b0;
        rank[i]  <= RW'(i);
      end
      cnt <= '0;
    end else begin
      if (cmd.install) begin
        valid[victim_way] <= 1'b1;
        dirty[victim_way] <= (cmd_q == CMD_PUT);
      end
      if (cmd.put_hit) begin
        dirty[hit_way] <= 1'b1;
      end
      if (cmd.clear_dirty) begin
        dirty[flush_way] <= 1'b0;
      end
      if (cmd.promote) begin
        for (int i = 0; i < WAYS; i++) begin
          if (AW'(i) == promo_way) begin
            rank[i] <= '0;
          end else if (rank[i] < rank[promo_way]) begin
            rank[i] <= rank[i] + 1'b1;
          end
        end
      end
      if (cmd.cnt_clr) begin
        cnt <= '0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind <= cmd.out_kind;
      last <= cmd.out_last;
      case (cmd.out_kind)
        KIND_HIT, KIND_WRITEBACK: begin
          out_index <= rdata[EW-1:RECORD_BITS];
          out_data  <= rdata[RECORD_BITS-1:0];
        end
        KIND_MISS: begin
          out_index <= idx_q;
          out_data  <= '0;
        end
        default: begin
          out_index <= '0;
          out_data  <= '0;
        end
      endcase
    end
  end

  assign status.cmd          = cmd_q;
  assign status.hit          = |hit_vec;
  assign status.victim_dirty = valid[victim_way] && dirty[victim_way];
  assign status.flush_dirty  = valid[flush_way] && dirty[flush_way];
  assign status.cnt_last     = (cnt == RW'(WAYS - 1));
  assign status.out_free     = !out_valid || !out_stall;

endmodule

/* rtl/core/lwbrc_ctrl.sv */
// Controller: sequences lookup, eviction, hit return and flush walk
`timescale 1ns / 1ps
module lwbrc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lwbrc_pkg::dp_status_t status,
  output lwbrc_pkg::ctrl_cmd_t  cmd
);
  import lwbrc_pkg::*;

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_LOOKUP     = 3'd1;
  localparam logic [2:0] S_EMIT_HIT   = 3'd2;
  localparam logic [2:0] S_EVICT      = 3'd3;
  localparam logic [2:0] S_FLUSH_SCAN = 3'd4;
  localparam logic [2:0] S_FLUSH_EMIT = 3'd5;
  localparam logic [2:0] S_DONE       = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        case (status.cmd)
          CMD_GET: begin
            if (status.hit) begin
              cmd.rd_en   = 1'b1;
              cmd.rd_src  = RD_HIT;
              cmd.promote = 1'b1;
              state_next  = S_EMIT_HIT;
            end else if (status.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_kind = KIND_MISS;
              cmd.out_last = 1'b1;
              state_next   = S_IDLE;
            end
          end
          CMD_FLUSH: begin
            cmd.cnt_clr = 1'b1;
            state_next  = S_FLUSH_SCAN;
          end
          default: begin
            if (status.hit) begin
              if (status.cmd == CMD_PUT) begin
                cmd.put_hit = 1'b1;
                cmd.promote = 1'b1;
              end
              state_next = S_IDLE;
            end else if (status.victim_dirty) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_src = RD_VICTIM;
              state_next = S_EVICT;
            end else begin
              cmd.install = 1'b1;
              cmd.promote = 1'b1;
              state_next  = S_IDLE;
            end
          end
        endcase
      end
      S_EMIT_HIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_HIT;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_EVICT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_WRITEBACK;
          cmd.out_last = 1'b1;
          cmd.install  = 1'b1;
          cmd.promote  = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FLUSH_SCAN: begin
        if (status.flush_dirty) begin
          cmd.rd_en       = 1'b1;
          cmd.rd_src      = RD_FLUSH;
          cmd.clear_dirty = 1'b1;
          state_next      = S_FLUSH_EMIT;
        end else if (status.cnt_last) begin
          state_next = S_DONE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_FLUSH_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_WRITEBACK;
          if (status.cnt_last) begin
            state_next = S_DONE;
          end else begin
            cmd.cnt_inc = 1'b1;
            state_next  = S_FLUSH_SCAN;
          end
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = KIND_DONE;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/lru_write_back_record_cache_unit.sv */
// The controller holds one item at a time and takes no new item until it is back in idle;
// hit and writeback data are read through the record RAM's single registered read port.
// Flush: a lookup, a scan of all WAYS entries with a writeback per dirty entry, then a done result.
// Reset: synchronous; clears valid and dirty bits, sets entry i to recency rank i.
// Top level: fully associative LRU write-back record cache
`timescale 1ns / 1ps
module lru_write_back_record_cache_unit #(
  parameter int WAYS        = 8,
  parameter int RECORD_BITS = 32,
  parameter int INDEX_BITS  = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             command,
  input  logic [INDEX_BITS-1:0]  record_index,
  input  logic [RECORD_BITS-1:0] record_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             kind,
  output logic [INDEX_BITS-1:0]  out_index,
  output logic [RECORD_BITS-1:0] out_data,
  output logic                   last
);
  import lwbrc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  lwbrc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  lwbrc_dpath #(
    .WAYS       (WAYS),
    .RECORD_BITS(RECORD_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .command     (command),
    .record_index(record_index),
    .record_data (record_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .kind        (kind),
    .out_index   (out_index),
    .out_data    (out_data),
    .last        (last)
  );

endmodule

/* rtl/core/lwbrc_checker.sv */
// Checker: port-level assertions for the record cache, bound to the top level
`timescale 1ns / 1ps
`include "lru_write_back_record_cache_unit_assert.svh"
module lwbrc_checker #(
  parameter int RECORD_BITS = 32,
  parameter int INDEX_BITS  = 32
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [1:0]             kind,
  input logic [INDEX_BITS-1:0]  out_index,
  input logic [RECORD_BITS-1:0] out_data,
  input logic                   last
);
  import lwbrc_pkg::*;

  `LWBRC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(kind) && $stable(out_index) && $stable(out_data) && $stable(last))
  `LWBRC_ASSERT_NOW(a_done_last, clk, rst, out_valid && (kind == KIND_DONE), last && (out_index == '0) && (out_data == '0))
  `LWBRC_ASSERT_NOW(a_miss_form, clk, rst, out_valid && (kind == KIND_MISS), last && (out_data == '0))
  `LWBRC_ASSERT_NOW(a_hit_last, clk, rst, out_valid && (kind == KIND_HIT), last)
  `LWBRC_ASSERT_NEXT(a_busy_after_in, clk, rst, in_valid && !in_stall, in_stall)

endmodule

bind lru_write_back_record_cache_unit lwbrc_checker #(
  .RECORD_BITS(RECORD_BITS),
  .INDEX_BITS (INDEX_BITS)
) u_lwbrc_checker (.*);
